[hdl/ldf_pkg.sv]
// ----------------------------------------------------------------------------
// ldf_pkg
// shared types and constants of the length prefix deframer
// ----------------------------------------------------------------------------
package ldf_pkg;

  localparam int unsigned HEADER_BYTES = 4;
  localparam int unsigned QUEUE_DEPTH  = 2;
  localparam int unsigned LEN_W        = 32;
  localparam int unsigned SEEN_W       = 2;

  typedef enum logic {
    ACT_BYTE  = 1'b0,
    ACT_RESET = 1'b1
  } ldf_action_e;

  typedef struct packed {
    logic       action;
    logic [7:0] data_byte;
  } ldf_in_t;

  typedef struct packed {
    logic [7:0]       body_byte;
    logic             last_of_package;
    logic             empty_package;
    logic             length_error;
    logic [LEN_W-1:0] package_length;
  } ldf_out_t;

  // front to queue write request
  typedef struct packed {
    logic     push;
    ldf_out_t data;
  } ldf_push_t;

endpackage

[hdl/ldf_front.sv]
// ----------------------------------------------------------------------------
// ldf_front
// header gather, length check, body count, one byte per cycle on accept_i
// ----------------------------------------------------------------------------
module ldf_front import ldf_pkg::*; #(
  parameter int unsigned HeaderBytes = HEADER_BYTES
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  ldf_in_t          in_data_i,
  input  logic             cfg_we_i,
  input  logic [LEN_W-1:0] cfg_wdata_i,
  output ldf_push_t        push_o
);

  localparam logic [SEEN_W-1:0] LastSeen = SEEN_W'(HeaderBytes - 1);

  logic              in_body_q, in_body_d;
  logic [SEEN_W-1:0] seen_q, seen_d;
  logic [LEN_W-1:0]  gather_q, gather_d;
  logic [LEN_W-1:0]  remain_q, remain_d;
  logic [LEN_W-1:0]  max_len_q;
  logic [LEN_W-1:0]  len_new;
  logic [LEN_W-1:0]  remain_dec;
  logic [7:0]        byte_in;

  assign byte_in    = in_data_i.data_byte;
  assign remain_dec = remain_q - LEN_W'(1);

  // little-endian byte placement
  always_comb begin
    case (seen_q)
      2'd0:    len_new = {24'd0, byte_in};
      2'd1:    len_new = gather_q | {16'd0, byte_in, 8'd0};
      2'd2:    len_new = gather_q | {8'd0, byte_in, 16'd0};
      2'd3:    len_new = gather_q | {byte_in, 24'd0};
      default: len_new = '0;
    endcase
  end

  always_comb begin
    in_body_d = in_body_q;
    seen_d    = seen_q;
    gather_d  = gather_q;
    remain_d  = remain_q;
    push_o    = '0;
    if (accept_i) begin
      if (in_data_i.action == ACT_RESET) begin
        in_body_d = 1'b0;
        seen_d    = '0;
        gather_d  = '0;
        remain_d  = '0;
      end else if (in_body_q) begin
        push_o.push                = 1'b1;
        push_o.data.body_byte      = byte_in;
        push_o.data.package_length = gather_q;
        remain_d                   = remain_dec;
        if (remain_dec == '0) begin
          push_o.data.last_of_package = 1'b1;
          in_body_d = 1'b0;
          seen_d    = '0;
          gather_d  = '0;
        end
      end else if (seen_q != LastSeen) begin
        seen_d   = seen_q + SEEN_W'(1);
        gather_d = len_new;
      end else begin
        seen_d = '0;
        if ((max_len_q != '0) && (len_new > max_len_q)) begin
          push_o.push                = 1'b1;
          push_o.data.length_error   = 1'b1;
          push_o.data.package_length = len_new;
          gather_d = '0;
          remain_d = '0;
        end else if (len_new == '0) begin
          push_o.push                 = 1'b1;
          push_o.data.last_of_package = 1'b1;
          push_o.data.empty_package   = 1'b1;
          gather_d = '0;
          remain_d = '0;
        end else begin
          in_body_d = 1'b1;
          gather_d  = len_new;
          remain_d  = len_new;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_body_q <= 1'b0;
      seen_q    <= '0;
      gather_q  <= '0;
      remain_q  <= '0;
      max_len_q <= '0;
    end else begin
      in_body_q <= in_body_d;
      seen_q    <= seen_d;
      gather_q  <= gather_d;
      remain_q  <= remain_d;
      if (cfg_we_i) begin
        max_len_q <= cfg_wdata_i;
      end
    end
  end

endmodule

[hdl/ldf_queue.sv]
// ----------------------------------------------------------------------------
// ldf_queue
// small result queue between the parser and the output stage
// ----------------------------------------------------------------------------
module ldf_queue import ldf_pkg::*; #(
  parameter int unsigned Depth = QUEUE_DEPTH
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  ldf_push_t push_i,
  input  logic      pop_i,
  output logic      full_o,
  output logic      empty_o,
  output ldf_out_t  head_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  ldf_out_t        mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign full_o  = (count_q == FullCnt);
  assign empty_o = (count_q == '0);
  assign do_push = push_i.push && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
    end
    case ({do_push, do_pop})
      2'b10:   count_d = count_q + CntW'(1);
      2'b01:   count_d = count_q - CntW'(1);
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_i.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

[hdl/ldf_back.sv]
// ----------------------------------------------------------------------------
// ldf_back
// output register that drains the result queue
// ----------------------------------------------------------------------------
module ldf_back import ldf_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     q_empty_i,
  input  ldf_out_t q_head_i,
  output logic     q_pop_o,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output ldf_out_t out_data_o
);

  logic     valid_q;
  ldf_out_t data_q;

  assign q_pop_o     = !q_empty_i && (!valid_q || !out_stall_i);
  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (q_pop_o) begin
      valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      data_q <= q_head_i;
    end
  end

endmodule

[hdl/length_prefix_deframer.sv]
// ----------------------------------------------------------------------------
// length_prefix_deframer
// splits a byte stream of little-endian length-prefixed packages into body
// byte results with last, empty and length error markers
// ----------------------------------------------------------------------------
// path: a result is written to the queue at the accepting edge, then loaded
//   into the output register once that is empty or its result is taken
// throughput: one input byte per cycle if the queue has room (one-byte parser)
// reset: rst_ni clears parse state, queue and max_length at once, no sweep
// ----------------------------------------------------------------------------
module length_prefix_deframer import ldf_pkg::*; #(
  parameter int unsigned HeaderBytes = HEADER_BYTES,
  parameter int unsigned QueueDepth  = QUEUE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  // input stream
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  ldf_in_t          in_data_i,
  // result stream
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output ldf_out_t         out_data_o,
  // max_length register
  input  logic             cfg_we_i,
  input  logic [LEN_W-1:0] cfg_wdata_i
);

  // front side stalls only on a full queue, never on out_stall_i directly
  logic      accept;
  ldf_push_t push;
  logic      q_full;
  logic      q_empty;
  logic      q_pop;
  ldf_out_t  q_head;

  assign in_stall_o = q_full;
  assign accept     = in_valid_i && !q_full;

  // parser: gathers header, checks limit, counts body bytes
  ldf_front #(
    .HeaderBytes (HeaderBytes)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .push_o      (push)
  );

  // decoupling queue, push and pop may happen in the same cycle
  ldf_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (q_pop),
    .full_o  (q_full),
    .empty_o (q_empty),
    .head_o  (q_head)
  );

  // output register, refilled whenever it empties or its transaction completes
  ldf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_head_i    (q_head),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

[tb/ldf_deframe_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ldf_deframe_checker
// watches both streams and the max_length port of the deframer, predicts each
// result from its own parse model and compares field by field in order
// ----------------------------------------------------------------------------
module ldf_deframe_checker import ldf_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_stall_i,
  input  ldf_in_t          in_data_i,
  input  logic             out_valid_i,
  input  logic             out_stall_i,
  input  ldf_out_t         out_data_i,
  input  logic             cfg_we_i,
  input  logic [LEN_W-1:0] cfg_wdata_i,
  output int unsigned      mismatches_o,
  output int unsigned      pending_o,
  output int unsigned      checked_o,
  output int unsigned      empty_packages_o,
  output int unsigned      length_errors_o
);

  ldf_out_t          expected_results[$];
  logic [LEN_W-1:0]  max_len;
  logic              in_body;
  logic [SEEN_W-1:0] hdr_seen;
  logic [LEN_W-1:0]  body_len;
  logic [LEN_W-1:0]  bytes_left;

  int unsigned mismatches = 0;
  int unsigned pending    = 0;
  int unsigned checked    = 0;
  int unsigned empties    = 0;
  int unsigned len_errors = 0;

  assign mismatches_o     = mismatches;
  assign pending_o        = pending;
  assign checked_o        = checked;
  assign empty_packages_o = empties;
  assign length_errors_o  = len_errors;

  function automatic void restart_hunt();
    in_body    = 1'b0;
    hdr_seen   = '0;
    body_len   = '0;
    bytes_left = '0;
  endfunction

  task automatic check_field(input string field, input logic [LEN_W-1:0] want,
                             input logic [LEN_W-1:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", field, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : deframe_model
    ldf_out_t predicted;
    ldf_out_t oldest;
    logic     produces;
    if (!rst_ni) begin
      max_len = '0;
      restart_hunt();
      expected_results.delete();
      pending = 0;
    end else begin
      // results first, a result never stems from a transaction of the same edge
      if (out_valid_i && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result: body_byte 0x%0h, package_length 0x%0h",
                 out_data_i.body_byte, out_data_i.package_length);
          mismatches++;
        end else begin
          oldest = expected_results.pop_front();
          pending--;
          check_field("body_byte", oldest.body_byte, out_data_i.body_byte);
          check_field("last_of_package", oldest.last_of_package,
                      out_data_i.last_of_package);
          check_field("empty_package", oldest.empty_package, out_data_i.empty_package);
          check_field("length_error", oldest.length_error, out_data_i.length_error);
          check_field("package_length", oldest.package_length,
                      out_data_i.package_length);
          checked++;
          if (oldest.empty_package) empties++;
          if (oldest.length_error) len_errors++;
        end
      end

      if (cfg_we_i) max_len = cfg_wdata_i;

      if (in_valid_i && !in_stall_i) begin
        predicted = '0;
        produces  = 1'b0;
        if (ldf_action_e'(in_data_i.action) == ACT_RESET) begin
          restart_hunt();
        end else if (in_body) begin
          bytes_left                = bytes_left - 1'b1;
          predicted.body_byte       = in_data_i.data_byte;
          predicted.package_length  = body_len;
          predicted.last_of_package = (bytes_left == '0);
          produces                  = 1'b1;
          if (bytes_left == '0) restart_hunt();
        end else begin
          // little-endian length, low byte first
          if (hdr_seen == '0) body_len = '0;
          body_len = body_len | (LEN_W'(in_data_i.data_byte) << (8 * hdr_seen));
          if (32'(hdr_seen) + 1 < HEADER_BYTES) begin
            hdr_seen = hdr_seen + 1'b1;
          end else begin
            hdr_seen = '0;
            if (max_len != '0 && body_len > max_len) begin
              predicted.length_error   = 1'b1;
              predicted.package_length = body_len;
              produces                 = 1'b1;
              restart_hunt();
            end else if (body_len == '0) begin
              predicted.last_of_package = 1'b1;
              predicted.empty_package   = 1'b1;
              produces                  = 1'b1;
              restart_hunt();
            end else begin
              in_body    = 1'b1;
              bytes_left = body_len;
            end
          end
        end
        if (produces) begin
          expected_results.push_back(predicted);
          pending++;
        end
      end
    end
  end

endmodule

[tb/length_prefix_deframer_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// length_prefix_deframer_tb
// drives length-prefixed byte streams with parse resets, cut-short packages
// and over-limit headers under several max_length settings, with random gaps
// on both streams; the checker beside the block predicts and compares
// ----------------------------------------------------------------------------
module length_prefix_deframer_tb;
  import ldf_pkg::*;

  // cycles allowed after the last expected result before a register write or
  // the verdict
  localparam int unsigned SETTLE_CYCLES = 8;
  // cycles with no transaction on any port before the run is called hung
  localparam int unsigned IDLE_LIMIT    = 2000;
  // minimum stream bytes per random phase
  localparam int unsigned PHASE_BYTES   = 255;
  localparam int unsigned NUM_PHASES    = 6;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_stall;
  ldf_in_t          in_data;
  logic             out_valid;
  logic             out_stall;
  ldf_out_t         out_data;
  logic             cfg_we;
  logic [LEN_W-1:0] cfg_wdata;

  int unsigned mismatches;
  int unsigned pending;
  int unsigned checked;
  int unsigned empty_packages;
  int unsigned length_errors;

  // stimulus bookkeeping
  int unsigned      stream_bytes = 0;
  int unsigned      parse_resets = 0;
  int unsigned      settings     = 0;
  logic [LEN_W-1:0] limit_now    = '0;
  // steady stretches: no gaps and no stalls on either side
  bit               steady       = 1'b0;

  logic        in_taken    = 1'b0;
  int unsigned idle_cycles = 0;

  length_prefix_deframer dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  ldf_deframe_checker u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .in_data_i        (in_data),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .out_data_i       (out_data),
    .cfg_we_i         (cfg_we),
    .cfg_wdata_i      (cfg_wdata),
    .mismatches_o     (mismatches),
    .pending_o        (pending),
    .checked_o        (checked),
    .empty_packages_o (empty_packages),
    .length_errors_o  (length_errors)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // input acceptance seen at the rising edge, read by the driver at the
  // falling edge so the driver never races the block's outputs
  always @(posedge clk) begin
    in_taken <= in_valid && !in_stall;
  end

  // watchdog: any transaction or register write counts as progress
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : watchdog
    wait (idle_cycles >= IDLE_LIMIT);
    $error("no transaction for %0d cycles", IDLE_LIMIT);
    $display("Verification failed");
    $finish;
  end

  // gap length: mostly none or short, now and then a long one
  function automatic int unsigned idle_gap();
    int unsigned r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // result side backpressure, alternating stall and run stretches
  initial begin : result_backpressure
    int unsigned hold;
    hold      = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        hold--;
      end else if (out_stall || steady) begin
        out_stall <= 1'b0;
        hold = steady ? 0 : $urandom_range(0, 10);
      end else begin
        hold = idle_gap();
        if (hold > 0) begin
          out_stall <= 1'b1;
          hold--;
        end
      end
    end
  end

  // one input transaction, starting and ending at a falling edge; valid stays
  // high after acceptance so back-to-back items need no extra assignment
  task automatic send_item(input ldf_action_e act, input logic [7:0] value);
    int unsigned gap;
    gap = idle_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{action: act, data_byte: value};
    do @(negedge clk); while (!in_taken);
    if (act == ACT_BYTE) stream_bytes++;
    else parse_resets++;
  endtask

  // header for len, then at most body_cap random body bytes when the block
  // is going to take a body at all under the current limit
  task automatic send_package(input logic [LEN_W-1:0] len, input int unsigned body_cap);
    int unsigned body_count;
    for (int i = 0; i < HEADER_BYTES; i++) send_item(ACT_BYTE, len[8*i +: 8]);
    body_count = 0;
    if (len != '0 && !(limit_now != '0 && len > limit_now)) begin
      body_count = (len < body_cap) ? len : body_cap;
    end
    repeat (body_count) send_item(ACT_BYTE, 8'($urandom()));
  endtask

  // register write only once the block has drained
  task automatic set_max_length(input logic [LEN_W-1:0] value);
    in_valid <= 1'b0;
    wait (pending == 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    limit_now = value;
    settings++;
  endtask

  initial begin : stimulus
    logic [LEN_W-1:0] phase_limits [NUM_PHASES];
    logic [LEN_W-1:0] len;
    longint unsigned  span;
    int unsigned      pick;
    int unsigned      phase_goal;

    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed part, max_length at its reset value of no limit
    // zero length package
    send_package(32'd0, 0);
    // two byte body at the byte extremes
    send_package(32'd2, 0);
    send_item(ACT_BYTE, 8'h00);
    send_item(ACT_BYTE, 8'hFF);
    // header cut short by a parse reset, its data byte ignored
    send_item(ACT_BYTE, 8'h01);
    send_item(ACT_BYTE, 8'h00);
    send_item(ACT_RESET, 8'hFF);
    // over-limit headers, the next byte starts a fresh header
    set_max_length(32'd3);
    send_package(32'd4, 0);
    send_package(32'hFFFF_FFFF, 0);

    // random phases: the limit extremes, tight limits and no limit
    phase_limits[0] = 32'hFFFF_FFFF;
    phase_limits[1] = 32'd1;
    phase_limits[2] = $urandom_range(2, 16);
    phase_limits[3] = 32'd0;
    phase_limits[4] = $urandom();
    phase_limits[5] = $urandom_range(20, 40);

    for (int p = 0; p < NUM_PHASES; p++) begin
      set_max_length(phase_limits[p]);
      phase_goal = stream_bytes + PHASE_BYTES;
      while (stream_bytes < phase_goal) begin
        if ($urandom_range(0, 49) == 0) steady = !steady;
        // mostly short bodies, some longer, and under a tight limit often
        // right up to it
        len = $urandom_range(0, 12);
        if ($urandom_range(0, 9) == 0) begin
          len = $urandom_range(13, 40);
        end else if (limit_now != '0 && limit_now < 40 && $urandom_range(0, 1) == 1) begin
          len = $urandom_range(0, limit_now);
        end
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
          // well-formed package
          send_package(len, '1);
        end else if (pick < 80 && limit_now != '0 && limit_now != '1) begin
          // length anywhere above the limit
          span = 64'hFFFF_FFFF - limit_now;
          send_package(LEN_W'(limit_now + 1 + ($urandom() % span)), 0);
        end else if (pick < 92) begin
          // broken sequence, always closed by a parse reset
          case ($urandom_range(0, 2))
            0: repeat ($urandom_range(1, 3)) send_item(ACT_BYTE, 8'($urandom()));
            1: send_package($urandom(), $urandom_range(0, 6));
            default: send_package(len, (len == '0) ? 0 : $urandom_range(0, len - 1));
          endcase
          send_item(ACT_RESET, 8'($urandom()));
        end else begin
          // noise: parse resets only
          repeat ($urandom_range(1, 3)) send_item(ACT_RESET, 8'($urandom()));
        end
      end
    end

    // drain, then let the pipeline settle
    in_valid <= 1'b0;
    wait (pending == 0);
    repeat (SETTLE_CYCLES) @(negedge clk);

    $display("run covered %0d stream bytes and %0d parse resets under %0d max_length values",
             stream_bytes, parse_resets, settings);
    $display("%0d results compared, %0d empty packages, %0d length errors",
             checked, empty_packages, length_errors);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
